@@ rtl/lsvm_pkg.sv @@
// Shared types and constants for the looped sample voice mixer.
// Holds the stream payload layouts, command and register codes, and field widths.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package lsvm_pkg;

    // Field widths
    localparam int ADDR_W      = 16;
    localparam int WAVE_DEPTH  = 65536;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 30;
    localparam int RATE_W      = 24;
    localparam int VOL_W       = 10;
    localparam int ACC_W       = 32;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [RATE_W-1:0] RATE_RESET = 24'd4096;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_START  = 2'd1,
        MODE_RENDER = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_START   = 3'd0,
        REG_WAVE_END     = 3'd1,
        REG_LOOP_START   = 3'd2,
        REG_LOOP_LENGTH  = 3'd3,
        REG_RATE_STEP    = 3'd4,
        REG_VOLUME_LEFT  = 3'd5,
        REG_VOLUME_RIGHT = 3'd6,
        REG_STEREO       = 3'd7
    } reg_idx_t;

    // Configuration register file contents
    typedef struct packed {
        logic [ADDR_W-1:0] wave_start;
        logic [ADDR_W-1:0] wave_end;
        logic [ADDR_W-1:0] loop_start;
        logic [ADDR_W-1:0] loop_length;
        logic [RATE_W-1:0] rate_step;
        logic [VOL_W-1:0]  volume_left;
        logic [VOL_W-1:0]  volume_right;
        logic              stereo;
    } cfg_t;

    // One classified command handed from the front to the back
    typedef struct packed {
        mode_t                    mode;
        logic [ADDR_W-1:0]        load_address;
        logic [BYTE_W-1:0]        load_byte;
        logic signed [ACC_W-1:0]  acc_left_in;
        logic signed [ACC_W-1:0]  acc_right_in;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/lsvm_front.sv @@
// Front end of the voice mixer: accepts input transactions, classifies them
// and holds them in a two-entry command queue for the back end.
// Depends on lsvm_pkg.
`default_nettype none

module lsvm_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lsvm_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [lsvm_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                                  q_valid,
    output lsvm_pkg::cmd_t                        q_cmd,
    input  wire logic                             q_pop
);
    import lsvm_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    cmd_t              queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              take;
    logic              push;
    logic              pop;
    cmd_t              in_cmd;

    // Classify the incoming item; an unknown kind is taken and dropped
    always_comb
    begin
        in_cmd.mode         = mode_t'(s_tuser);
        in_cmd.load_address = s_tdata[15:0];
        in_cmd.load_byte    = s_tdata[23:16];
        in_cmd.acc_left_in  = s_tdata[55:24];
        in_cmd.acc_right_in = s_tdata[87:56];
        case (mode_t'(s_tuser))
            MODE_LOAD, MODE_START, MODE_RENDER: push = take;
            default:                            push = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign take     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = queue_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    // Advance queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store command payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lsvm_back.sv @@
// Back end of the voice mixer: wave memory, voice state, interpolation and
// mixing sequencer, and the output register of the result stream.
// Depends on lsvm_pkg; fed by lsvm_front through its command queue.
`default_nettype none

module lsvm_back #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lsvm_pkg::cfg_t                    cfg,
    input  wire logic                              q_valid,
    input  wire lsvm_pkg::cmd_t                    q_cmd,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lsvm_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import lsvm_pkg::*;

    localparam int PROD_W    = FRAC_BITS + BYTE_W + 2;
    localparam int OSUM_W    = POS_W + 1;
    localparam int LOOPSH_W  = ADDR_W + FRAC_BITS;
    localparam int OLOOP_W   = ((OSUM_W > LOOPSH_W) ? OSUM_W : LOOPSH_W) + 2;
    localparam int CONTRIB_W = 20;
    localparam int MULT_W    = BYTE_W + VOL_W;
    localparam int OFF_W     = VOL_W + 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_EMIT
    } state_t;

    // Wave memory
    logic [BYTE_W-1:0] wave_mem [WAVE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;

    // Sequencer and voice state
    state_t                     state_reg, state_next;
    logic signed [POS_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]          seg_end_reg, seg_end_next;
    logic                       playing_reg, playing_next;
    logic                       live_reg, live_next;
    logic signed [ACC_W-1:0]    accl_reg, accl_next;
    logic signed [ACC_W-1:0]    accr_reg, accr_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [BYTE_W-1:0]          s0_reg, s0_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [OSUM_W-1:0]   osum_reg, osum_next;
    logic signed [OLOOP_W-1:0]  oloop_reg, oloop_next;
    logic signed [CONTRIB_W-1:0] contrib_l_reg, contrib_l_next;
    logic signed [CONTRIB_W-1:0] contrib_r_reg, contrib_r_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]    out_accl_reg, out_accl_next;
    logic signed [ACC_W-1:0]    out_accr_reg, out_accr_next;
    logic                       out_active_reg, out_active_next;

    // Datapath terms
    logic signed [POS_W-1:0]    ip_full;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          seg_span;
    logic [POS_W-1:0]           start_pos;
    logic signed [FRAC_BITS:0]  frac_s;
    logic signed [BYTE_W:0]     diff_s;
    logic signed [PROD_W-1:0]   interp_shift;
    logic [BYTE_W-1:0]          du;
    logic [VOL_W:0]             vsum;
    logic [VOL_W-1:0]           mult_l;
    logic [OFF_W-1:0]           off_l;
    logic [MULT_W-1:0]          pl;
    logic [MULT_W-1:0]          pr;
    logic                       out_free;

    // Current read address and start position
    always_comb
    begin
        ip_full   = pos_reg >>> FRAC_BITS;
        rd_addr   = ADDR_W'(seg_end_reg + ip_full[ADDR_W-1:0]);
        seg_span  = ADDR_W'(cfg.wave_end - cfg.wave_start);
        start_pos = POS_W'(0) - (POS_W'(seg_span) << FRAC_BITS);
    end

    // Interpolation and volume terms
    always_comb
    begin
        frac_s       = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
        diff_s       = $signed({1'b0, rdata_reg}) - $signed({1'b0, s0_reg});
        interp_shift = prod_reg >>> FRAC_BITS;
        du           = BYTE_W'(s0_reg + interp_shift[BYTE_W-1:0]);
        vsum         = {1'b0, cfg.volume_left} + {1'b0, cfg.volume_right};
        mult_l       = cfg.stereo ? cfg.volume_left : vsum[VOL_W:1];
        off_l        = cfg.stereo ? {cfg.volume_left, 7'd0} : {vsum, 6'd0};
        pl           = du * mult_l;
        pr           = du * cfg.volume_right;
    end

    assign out_free = !out_valid_reg || m_tready;

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        seg_end_next    = seg_end_reg;
        playing_next    = playing_reg;
        live_next       = live_reg;
        accl_next       = accl_reg;
        accr_next       = accr_reg;
        addr_next       = addr_reg;
        s0_next         = s0_reg;
        prod_next       = prod_reg;
        osum_next       = osum_reg;
        oloop_next      = oloop_reg;
        contrib_l_next  = contrib_l_reg;
        contrib_r_next  = contrib_r_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_accl_next   = out_accl_reg;
        out_accr_next   = out_accr_reg;
        out_active_next = out_active_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.mode)
                        MODE_LOAD:
                        begin
                            mem_we   = 1'b1;
                            mem_addr = q_cmd.load_address;
                        end
                        MODE_START:
                        begin
                            seg_end_next = cfg.wave_end;
                            pos_next     = $signed(start_pos);
                            playing_next = (seg_span != '0);
                        end
                        MODE_RENDER:
                        begin
                            accl_next = q_cmd.acc_left_in;
                            accr_next = q_cmd.acc_right_in;
                            live_next = playing_reg;
                            if (playing_reg)
                            begin
                                mem_addr   = rd_addr;
                                addr_next  = rd_addr;
                                state_next = ST_RD1;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD1:
            begin
                s0_next    = rdata_reg;
                mem_addr   = ADDR_W'(addr_reg + 1'b1);
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                prod_next  = frac_s * diff_s;
                osum_next  = OSUM_W'(pos_reg) + $signed(OSUM_W'(cfg.rate_step));
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                contrib_l_next = $signed({2'b00, pl}) - $signed({3'b000, off_l});
                contrib_r_next = cfg.stereo ?
                    ($signed({2'b00, pr}) - $signed({3'b000, cfg.volume_right, 7'd0})) :
                    '0;
                oloop_next = OLOOP_W'(osum_reg)
                    - $signed(OLOOP_W'({cfg.loop_length, FRAC_BITS'(0)}));
                state_next = ST_MUL == state_reg ? ST_EMIT : state_reg;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_active_next = 1'b0;
                    out_accl_next   = accl_reg;
                    out_accr_next   = accr_reg;
                    if (live_reg)
                    begin
                        out_accl_next = ACC_W'(accl_reg + ACC_W'(contrib_l_reg));
                        out_accr_next = ACC_W'(accr_reg + ACC_W'(contrib_r_reg));
                        out_active_next = 1'b1;
                        pos_next = osum_reg[POS_W-1:0];
                        // Passed the segment end: stop or wrap into the loop
                        if (!osum_reg[OSUM_W-1])
                        begin
                            if (cfg.loop_length == '0)
                            begin
                                playing_next    = 1'b0;
                                out_active_next = 1'b0;
                            end
                            else
                            begin
                                seg_end_next    = ADDR_W'(cfg.loop_start + cfg.loop_length);
                                pos_next        = oloop_reg[POS_W-1:0];
                                playing_next    = oloop_reg[OLOOP_W-1];
                                out_active_next = oloop_reg[OLOOP_W-1];
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state, voice state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            seg_end_reg    <= '0;
            playing_reg    <= 1'b0;
            live_reg       <= 1'b0;
            accl_reg       <= '0;
            accr_reg       <= '0;
            addr_reg       <= '0;
            s0_reg         <= '0;
            prod_reg       <= '0;
            osum_reg       <= '0;
            oloop_reg      <= '0;
            contrib_l_reg  <= '0;
            contrib_r_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_accl_reg   <= '0;
            out_accr_reg   <= '0;
            out_active_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            seg_end_reg    <= seg_end_next;
            playing_reg    <= playing_next;
            live_reg       <= live_next;
            accl_reg       <= accl_next;
            accr_reg       <= accr_next;
            addr_reg       <= addr_next;
            s0_reg         <= s0_next;
            prod_reg       <= prod_next;
            osum_reg       <= osum_next;
            oloop_reg      <= oloop_next;
            contrib_l_reg  <= contrib_l_next;
            contrib_r_reg  <= contrib_r_next;
            out_valid_reg  <= out_valid_next;
            out_accl_reg   <= out_accl_next;
            out_accr_reg   <= out_accr_next;
            out_active_reg <= out_active_next;
        end
    end

    // Single-port wave memory with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[mem_addr] <= q_cmd.load_byte;
        end
        rdata_reg <= wave_mem[mem_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_active_reg, out_accr_reg, out_accl_reg};

endmodule

`default_nettype wire

@@ rtl/looped_sample_voice_mixer.sv @@
// Top level of the looped sample voice mixer: configuration registers and the
// front and back halves joined by the command queue.
// Depends on lsvm_pkg, lsvm_front and lsvm_back.
//
// Usage:
//   s_axis carries one item per transaction. tuser selects the kind: load a
//   wave byte, start the voice, or render one sample. Load and start give no
//   result; a render gives one result transaction on m_axis.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only while
//   no item is in flight.
//   Path: a render taken into an empty block passes the command queue, ST_IDLE,
//   ST_RD1, ST_RD2, ST_MUL, ST_EMIT and the output register (only ST_IDLE and
//   ST_EMIT when the voice is stopped). A playing render holds the back end for two
//   byte reads through the one memory port, the blend multiply, the volume multiply
//   and the output load; a load or start is done in ST_IDLE, which alone pops.
//   The two-entry command queue lets the sender run ahead of the back end.
//   Reset clears the voice (stopped, position zero) and the registers to their
//   defaults; wave memory content is undefined until loaded.
//   A stalled m_axis keeps its result; the back end waits at its output stage
//   while the queue keeps taking items until full, then drops s_axis_tready.
`default_nettype none

module looped_sample_voice_mixer #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // load_address[15:0], load_byte[23:16], acc_left_in[55:24], acc_right_in[87:56]
    input  wire logic [lsvm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  wire logic [lsvm_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // acc_left_out[31:0], acc_right_out[63:32], voice_active[64], zero[71:65]
    output logic [lsvm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [lsvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lsvm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lsvm_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_start   <= '0;
            cfg_reg.wave_end     <= '0;
            cfg_reg.loop_start   <= '0;
            cfg_reg.loop_length  <= '0;
            cfg_reg.rate_step    <= RATE_RESET;
            cfg_reg.volume_left  <= '0;
            cfg_reg.volume_right <= '0;
            cfg_reg.stereo       <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WAVE_START:   cfg_reg.wave_start   <= cfg_data[ADDR_W-1:0];
                REG_WAVE_END:     cfg_reg.wave_end     <= cfg_data[ADDR_W-1:0];
                REG_LOOP_START:   cfg_reg.loop_start   <= cfg_data[ADDR_W-1:0];
                REG_LOOP_LENGTH:  cfg_reg.loop_length  <= cfg_data[ADDR_W-1:0];
                REG_RATE_STEP:    cfg_reg.rate_step    <= cfg_data[RATE_W-1:0];
                REG_VOLUME_LEFT:  cfg_reg.volume_left  <= cfg_data[VOL_W-1:0];
                REG_VOLUME_RIGHT: cfg_reg.volume_right <= cfg_data[VOL_W-1:0];
                REG_STEREO:       cfg_reg.stereo       <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lsvm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    lsvm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/lsvm_checker.sv @@
// Port-level checks for the looped sample voice mixer, bound to the top level.
// Depends on lsvm_pkg and looped_sample_voice_mixer.
`default_nettype none

module lsvm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [lsvm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // Hold a stalled result
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result right after reset release
    a_no_result_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result shown right after reset");

    // Queue fills only through an accepted transaction
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without a transaction");

endmodule

bind looped_sample_voice_mixer lsvm_checker u_lsvm_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking bench for the looped sample voice mixer: sends load, start and render
// transactions with random gaps and output stalls, and checks every mix result.
// Depends on lsvm_pkg and the looped_sample_voice_mixer RTL.
module testbench;
    import lsvm_pkg::*;

    localparam int FRAC_BITS    = 12;
    localparam int ITEM_TARGET  = 410;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam logic [IN_TUSER_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACC_W-1:0] left;
        logic [ACC_W-1:0] right;
        logic             active;
    } mix_result_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    // Voice shadow: registers, wave memory and playback state
    cfg_t              voice_cfg;
    logic [BYTE_W-1:0] wave_mem [WAVE_DEPTH];
    bit                wave_loaded [WAVE_DEPTH];
    logic [POS_W-1:0]  voice_pos;
    logic [ADDR_W-1:0] seg_end;
    logic              voice_on;

    mix_result_t expected_mix[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          sink_wait      = 0;
    int          quiet_cycles   = 0;
    bit          idle_on        = 1'b0;

    looped_sample_voice_mixer #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 19) : 0;
    endfunction

    function automatic logic [ACC_W-1:0] pick_acc();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume();
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return VOL_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Byte address of the lower sample at the current play position
    function automatic logic [ADDR_W-1:0] sample_addr();
        longint offs;
        longint whole;
        offs  = longint'($signed(voice_pos));
        whole = offs >>> FRAC_BITS;
        return seg_end + whole[ADDR_W-1:0];
    endfunction

    // Advance the voice shadow by one accepted item and queue a render's mix result
    task automatic play_voice_item(logic [IN_TUSER_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                   logic [BYTE_W-1:0] data, logic [ACC_W-1:0] acc_l,
                                   logic [ACC_W-1:0] acc_r);
        longint      offs;
        longint      frac;
        longint      s0;
        longint      s1;
        longint      blend;
        longint      vl;
        longint      vr;
        longint      vsum;
        longint      lsum;
        longint      rsum;
        logic [ADDR_W-1:0] a0;
        logic [ADDR_W-1:0] a1;
        logic [ADDR_W-1:0] span;
        mix_result_t res;
        case (kind)
            MODE_LOAD:
            begin
                wave_mem[addr]    = data;
                wave_loaded[addr] = 1'b1;
            end
            MODE_START:
            begin
                span      = voice_cfg.wave_end - voice_cfg.wave_start;
                seg_end   = voice_cfg.wave_end;
                offs      = -(longint'(span) << FRAC_BITS);
                voice_pos = offs[POS_W-1:0];
                voice_on  = (span != '0);
            end
            MODE_RENDER:
            begin
                res.left  = acc_l;
                res.right = acc_r;
                if (voice_on)
                begin
                    offs  = longint'($signed(voice_pos));
                    frac  = offs & ((64'sd1 << FRAC_BITS) - 1);
                    a0    = sample_addr();
                    a1    = a0 + 16'd1;
                    s0    = longint'(wave_mem[a0]);
                    s1    = longint'(wave_mem[a1]);
                    blend = s0 + ((frac * (s1 - s0)) >>> FRAC_BITS);
                    vl    = longint'(voice_cfg.volume_left);
                    vr    = longint'(voice_cfg.volume_right);
                    // Mix into both sides, or into the left side only in mono
                    if (voice_cfg.stereo)
                    begin
                        lsum      = longint'(acc_l) + blend * vl - 128 * vl;
                        rsum      = longint'(acc_r) + blend * vr - 128 * vr;
                        res.left  = lsum[ACC_W-1:0];
                        res.right = rsum[ACC_W-1:0];
                    end
                    else
                    begin
                        vsum     = vl + vr;
                        lsum     = longint'(acc_l) + blend * (vsum >> 1) - (vsum << 6);
                        res.left = lsum[ACC_W-1:0];
                    end
                    // Step forward; wrap into the loop or stop past the segment end
                    offs = offs + longint'(voice_cfg.rate_step);
                    if (offs >= 0)
                    begin
                        if (voice_cfg.loop_length == '0)
                            voice_on = 1'b0;
                        else
                        begin
                            seg_end = voice_cfg.loop_start + voice_cfg.loop_length;
                            offs    = offs - (longint'(voice_cfg.loop_length) << FRAC_BITS);
                            if (offs >= 0)
                                voice_on = 1'b0;
                        end
                    end
                    voice_pos = offs[POS_W-1:0];
                end
                res.active = voice_on;
                expected_mix.push_back(res);
            end
            default:
            begin
                // unused mode: dropped by the block
            end
        endcase
    endtask

    // Send one input transaction after a random gap, then update the shadow
    task automatic send_item(logic [IN_TUSER_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [BYTE_W-1:0] data, logic [ACC_W-1:0] acc_l,
                             logic [ACC_W-1:0] acc_r);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc_r, acc_l, data, addr};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind != MODE_UNUSED)
            items_sent++;
        play_voice_item(kind, addr, data, acc_l, acc_r);
    endtask

    // Load any wave byte the next render would read before it is written, then render
    task automatic send_render(logic [ACC_W-1:0] acc_l, logic [ACC_W-1:0] acc_r);
        logic [ADDR_W-1:0] a0;
        logic [ADDR_W-1:0] a1;
        if (voice_on)
        begin
            a0 = sample_addr();
            a1 = a0 + 16'd1;
            if (!wave_loaded[a0])
                send_item(MODE_LOAD, a0, BYTE_W'($urandom), $urandom, $urandom);
            if (!wave_loaded[a1])
                send_item(MODE_LOAD, a1, BYTE_W'($urandom), $urandom, $urandom);
        end
        send_item(MODE_RENDER, ADDR_W'($urandom), BYTE_W'($urandom), acc_l, acc_r);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_WAVE_START:   voice_cfg.wave_start   = value[ADDR_W-1:0];
            REG_WAVE_END:     voice_cfg.wave_end     = value[ADDR_W-1:0];
            REG_LOOP_START:   voice_cfg.loop_start   = value[ADDR_W-1:0];
            REG_LOOP_LENGTH:  voice_cfg.loop_length  = value[ADDR_W-1:0];
            REG_RATE_STEP:    voice_cfg.rate_step    = value[RATE_W-1:0];
            REG_VOLUME_LEFT:  voice_cfg.volume_left  = value[VOL_W-1:0];
            REG_VOLUME_RIGHT: voice_cfg.volume_right = value[VOL_W-1:0];
            REG_STEREO:       voice_cfg.stereo       = value[0];
            default:          ;
        endcase
    endtask

    // Write all eight registers; call only while the block is idle
    task automatic apply_voice_config(logic [ADDR_W-1:0] ws, logic [ADDR_W-1:0] we,
                                      logic [ADDR_W-1:0] ls, logic [ADDR_W-1:0] ll,
                                      logic [RATE_W-1:0] rate, logic [VOL_W-1:0] vl,
                                      logic [VOL_W-1:0] vr, logic st);
        write_reg(REG_WAVE_START, CFG_DATA_W'(ws));
        write_reg(REG_WAVE_END, CFG_DATA_W'(we));
        write_reg(REG_LOOP_START, CFG_DATA_W'(ls));
        write_reg(REG_LOOP_LENGTH, CFG_DATA_W'(ll));
        write_reg(REG_RATE_STEP, rate);
        write_reg(REG_VOLUME_LEFT, CFG_DATA_W'(vl));
        write_reg(REG_VOLUME_RIGHT, CFG_DATA_W'(vr));
        write_reg(REG_STEREO, CFG_DATA_W'(st));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop tvalid, wait for every queued result, then let the pipeline settle
    task automatic wait_voice_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string field, logic [ACC_W-1:0] got,
                                   logic [ACC_W-1:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    task automatic check_mix(logic [OUT_TDATA_W-1:0] word);
        mix_result_t want;
        if (expected_mix.size() == 0)
        begin
            report_mismatch("unexpected result", word[31:0], '0);
            return;
        end
        want = expected_mix.pop_front();
        if (word[31:0] !== want.left)
            report_mismatch("acc_left_out", word[31:0], want.left);
        if (word[63:32] !== want.right)
            report_mismatch("acc_right_out", word[63:32], want.right);
        if (word[64] !== want.active)
            report_mismatch("voice_active", {31'd0, word[64]}, {31'd0, want.active});
    endtask

    // Stopped voice: renders pass the accumulators, an empty start and an unused mode
    task automatic test_idle_voice();
        idle_on = 1'b0;
        send_render(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(MODE_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom), $urandom, $urandom);
        send_item(MODE_START, ADDR_W'($urandom), BYTE_W'($urandom), $urandom, $urandom);
        send_render(32'hFFFF_FFFF, 32'h0000_0000);
        wait_voice_idle();
    endtask

    // Segment across the top of the address space, looping back over the wrap
    task automatic test_wrapped_loop();
        logic [BYTE_W-1:0] wave_bytes [8];
        int k;
        wave_bytes = '{8'h00, 8'hFF, 8'h11, 8'hFF, 8'h00, 8'hC8, 8'h01, 8'h63};
        idle_on = 1'b1;
        apply_voice_config(16'hFFFC, 16'h0003, 16'hFFFE, 16'd3, 24'h001800,
                           10'd1023, 10'd0, 1'b1);
        for (k = 0; k < 8; k++)
            send_item(MODE_LOAD, 16'hFFFC + k[15:0], wave_bytes[k], pick_acc(), pick_acc());
        send_item(MODE_START, ADDR_W'($urandom), BYTE_W'($urandom), $urandom, $urandom);
        send_render(32'h8000_0000, 32'h8000_0000);
        send_render(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        repeat (4) send_render(pick_acc(), pick_acc());
        wait_voice_idle();
    endtask

    // Mono at full volume; the largest step overshoots even the new loop end
    task automatic test_mono_overshoot();
        idle_on = 1'b0;
        apply_voice_config(16'hFFFC, 16'h0003, 16'hFFFE, 16'd2, 24'hFF_FFFF,
                           10'd1023, 10'd1023, 1'b0);
        send_item(MODE_START, ADDR_W'($urandom), BYTE_W'($urandom), $urandom, $urandom);
        send_render(32'h7FFF_FFFF, 32'h8000_0000);
        send_render(32'h8000_0000, 32'h7FFF_FFFF);
        wait_voice_idle();
    endtask

    // One-shot segment: the last sample is mixed, then the voice stops
    task automatic test_play_once();
        idle_on = 1'b1;
        apply_voice_config(16'h0001, 16'h0002, 16'h0000, 16'd0, 24'h001000,
                           10'd0, 10'd1023, 1'b1);
        send_item(MODE_START, ADDR_W'($urandom), BYTE_W'($urandom), $urandom, $urandom);
        send_render(pick_acc(), pick_acc());
        send_render(pick_acc(), pick_acc());
        wait_voice_idle();
    endtask

    // Random voices: start, then mostly renders with loads, noise and restarts
    task automatic test_random_voices();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] loop_len;
        logic [RATE_W-1:0] step;
        int steps;
        int pick;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            base = ADDR_W'($urandom);
            case ($urandom_range(0, 9))
                0:       span = 16'd0;
                1:       span = ADDR_W'($urandom);
                default: span = ADDR_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 7))
                0, 1:    loop_len = 16'd0;
                2:       loop_len = 16'hFFFF;
                3:       loop_len = ADDR_W'($urandom);
                default: loop_len = ADDR_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 9))
                0:       step = 24'd0;
                1:       step = 24'hFF_FFFF;
                2:       step = RATE_W'($urandom);
                default: step = RATE_W'($urandom_range(256, 12288));
            endcase
            apply_voice_config(base, base + span, ADDR_W'($urandom), loop_len, step,
                               pick_volume(), pick_volume(), 1'($urandom_range(0, 1)));
            send_item(MODE_START, ADDR_W'($urandom), BYTE_W'($urandom), $urandom, $urandom);
            steps = $urandom_range(8, 40);
            repeat (steps)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    send_render(pick_acc(), pick_acc());
                else if (pick < 88)
                    send_item(MODE_LOAD, ADDR_W'($urandom), BYTE_W'($urandom),
                              $urandom, $urandom);
                else if (pick < 93)
                    send_item(MODE_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom),
                              $urandom, $urandom);
                else
                    send_item(MODE_START, ADDR_W'($urandom), BYTE_W'($urandom),
                              $urandom, $urandom);
            end
            wait_voice_idle();
        end
    endtask

    // Check each result transaction and draw the next output stall
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_mix(m_axis_tdata);
            sink_wait = draw_wait();
            m_axis_tready <= (sink_wait == 0);
        end
        else if (sink_wait > 0)
        begin
            sink_wait = sink_wait - 1;
            m_axis_tready <= (sink_wait == 0);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        voice_cfg           = '0;
        voice_cfg.rate_step = RATE_RESET;
        voice_cfg.stereo    = 1'b1;
        voice_pos           = '0;
        seg_end             = '0;
        voice_on            = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_voice();
        test_wrapped_loop();
        test_mono_overshoot();
        test_play_once();
        test_random_voices();
        wait_voice_idle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
